### hw/rtl/eopg_pkg.sv
// Package for the ellipse outline point generator.
// Holds the shared constants, the overlay mode codes and the arctangent table.
// No dependencies.
`timescale 1ns / 1ps

package eopg_pkg;

   // Default field widths
   localparam int COORD_BITS_DEF = 12;
   localparam int ANGLE_BITS_DEF = 16;

   // Fixed field widths
   localparam int REG_W  = 13;
   localparam int IDX_W  = 13;
   localparam int MODE_W = 2;

   // CORDIC datapath: x/y in Q30 with headroom, z in 2^-32 turn units
   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_W     = 34;
   localparam int Z_W          = 32;
   localparam int FRAC_BITS    = 30;
   localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(652032874);

   // Overlay register reset value
   localparam logic [REG_W-1:0] OVERLAY_RESET = REG_W'(4096);

   // Register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE   = 2'd0,
      MODE_COMMIT = 2'd1,
      MODE_LIVE   = 2'd2
   } mode_type;

   // atan(2^-k) in 2^-32 turn units
   function automatic logic signed [Z_W-1:0] atan_turn32(input int k);
      logic signed [Z_W-1:0] v;
      case (k)
         0:  v = 32'sd536870912;
         1:  v = 32'sd316933406;
         2:  v = 32'sd167458907;
         3:  v = 32'sd85004756;
         4:  v = 32'sd42667331;
         5:  v = 32'sd21354465;
         6:  v = 32'sd10679838;
         7:  v = 32'sd5340245;
         8:  v = 32'sd2670163;
         9:  v = 32'sd1335087;
         10: v = 32'sd667544;
         11: v = 32'sd333772;
         12: v = 32'sd166886;
         13: v = 32'sd83443;
         14: v = 32'sd41722;
         15: v = 32'sd20861;
         16: v = 32'sd10430;
         17: v = 32'sd5215;
         18: v = 32'sd2608;
         19: v = 32'sd1304;
         20: v = 32'sd652;
         21: v = 32'sd326;
         22: v = 32'sd163;
         23: v = 32'sd81;
         24: v = 32'sd41;
         25: v = 32'sd20;
         26: v = 32'sd10;
         27: v = 32'sd5;
         28: v = 32'sd3;
         29: v = 32'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/eopg_setup.sv
// Entry stage: center, radii, segment count and the per-word flags.
// Depends on eopg_pkg.
`timescale 1ns / 1ps

module eopg_setup #(
   parameter int COORD_BITS = eopg_pkg::COORD_BITS_DEF,
   parameter int SIDE_W     = 4 * COORD_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [COORD_BITS-1:0]         start_x,
   input  logic [COORD_BITS-1:0]         start_y,
   input  logic [COORD_BITS-1:0]         end_x,
   input  logic [COORD_BITS-1:0]         end_y,
   input  logic [eopg_pkg::MODE_W-1:0]   overlay_mode,
   input  logic [eopg_pkg::IDX_W-1:0]    sample_index,
   output logic                          out_valid,
   output logic [SIDE_W-1:0]             side,
   output logic [COORD_BITS:0]           segs,
   output logic [COORD_BITS:0]           rem_init
);
   import eopg_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int CMP = (C + 1 > IDX_W) ? C + 1 : IDX_W;

   logic [C:0]   sum_x, sum_y, dif_x, dif_y;
   logic [C-1:0] cx, cy;
   logic [C-2:0] rx, ry, rmax;
   logic [C:0]   segs_in;
   logic         mode_ok, preview, live, last;
   logic [CMP-1:0] idx_w, segs_w;

   logic             vld_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [C:0]       segs_ff, rem_ff;

   // Center and half extents
   always_comb begin
      sum_x   = {1'b0, start_x} + {1'b0, end_x};
      sum_y   = {1'b0, start_y} + {1'b0, end_y};
      dif_x   = (end_x > start_x) ? {1'b0, end_x} - {1'b0, start_x}
                                  : {1'b0, start_x} - {1'b0, end_x};
      dif_y   = (end_y > start_y) ? {1'b0, end_y} - {1'b0, start_y}
                                  : {1'b0, start_y} - {1'b0, end_y};
      cx      = sum_x[C:1];
      cy      = sum_y[C:1];
      rx      = dif_x[C-1:1];
      ry      = dif_y[C-1:1];
      rmax    = (rx > ry) ? rx : ry;
      segs_in = {rmax, 2'b00};
   end

   // Flags
   always_comb begin
      mode_ok = (overlay_mode == MODE_COMMIT) || (overlay_mode == MODE_LIVE);
      preview = (overlay_mode == MODE_LIVE);
      idx_w   = CMP'(sample_index);
      segs_w  = CMP'(segs_in);
      live    = mode_ok && (rx != '0) && (ry != '0) && (idx_w < segs_w);
      last    = live && (idx_w == segs_w - CMP'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= {last, live, preview, ry, rx, cy, cx};
         segs_ff <= segs_in;
         rem_ff  <= live ? (C + 1)'(sample_index) : '0;
      end
   end

   assign out_valid = vld_ff;
   assign side      = side_ff;
   assign segs      = segs_ff;
   assign rem_init  = rem_ff;

endmodule

### hw/rtl/eopg_divider.sv
// Pipelined restoring divider: angle = floor(index * 2^ANGLE_BITS / segs).
// One quotient bit per stage. Depends on eopg_pkg.
`timescale 1ns / 1ps

module eopg_divider #(
   parameter int COORD_BITS = eopg_pkg::COORD_BITS_DEF,
   parameter int ANGLE_BITS = eopg_pkg::ANGLE_BITS_DEF,
   parameter int SIDE_W     = 4 * COORD_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [SIDE_W-1:0]     in_side,
   input  logic [COORD_BITS:0]   segs,
   input  logic [COORD_BITS:0]   rem_init,
   output logic                  out_valid,
   output logic [SIDE_W-1:0]     out_side,
   output logic [ANGLE_BITS-1:0] angle
);
   import eopg_pkg::*;

   localparam int C = COORD_BITS;
   localparam int A = ANGLE_BITS;

   logic              vld_ff  [A];
   logic [SIDE_W-1:0] side_ff [A];
   logic [C:0]        segs_ff [A];
   logic [C:0]        rem_ff  [A];
   logic [A-1:0]      quo_ff  [A];

   for (genvar k = 0; k < A; k++) begin : g_stage
      logic              v_prev;
      logic [SIDE_W-1:0] s_prev;
      logic [C:0]        d_prev, r_prev;
      logic [A-1:0]      q_prev;
      logic [C+1:0]      rem2;
      logic              ge;
      logic [C:0]        rem_in;
      logic [A-1:0]      quo_in;

      if (k == 0) begin : g_first
         assign v_prev = in_valid;
         assign s_prev = in_side;
         assign d_prev = segs;
         assign r_prev = rem_init;
         assign q_prev = '0;
      end else begin : g_next
         assign v_prev = vld_ff[k-1];
         assign s_prev = side_ff[k-1];
         assign d_prev = segs_ff[k-1];
         assign r_prev = rem_ff[k-1];
         assign q_prev = quo_ff[k-1];
      end

      // Shift in a zero bit, subtract the divisor when it fits
      always_comb begin
         rem2   = {r_prev, 1'b0};
         ge     = (rem2 >= {1'b0, d_prev});
         rem_in = ge ? (C + 1)'(rem2 - {1'b0, d_prev}) : (C + 1)'(rem2);
         quo_in = {q_prev[A-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= s_prev;
            segs_ff[k] <= d_prev;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[A-1];
   assign out_side  = side_ff[A-1];
   assign angle     = quo_ff[A-1];

endmodule

### hw/rtl/eopg_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Gives cos/sin of the angle within its quadrant in Q30. Depends on eopg_pkg.
`timescale 1ns / 1ps

module eopg_cordic #(
   parameter int ANGLE_BITS = eopg_pkg::ANGLE_BITS_DEF,
   parameter int SIDE_W     = 49
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [SIDE_W-1:0]                   in_side,
   input  logic [ANGLE_BITS-1:0]               angle,
   output logic                                out_valid,
   output logic [SIDE_W-1:0]                   out_side,
   output logic [1:0]                          quad,
   output logic signed [eopg_pkg::CORDIC_W-1:0] cos_q,
   output logic signed [eopg_pkg::CORDIC_W-1:0] sin_q
);
   import eopg_pkg::*;

   localparam int A = ANGLE_BITS;
   localparam int N = CORDIC_STEPS;

   logic                       vld_ff  [N];
   logic [SIDE_W-1:0]          side_ff [N];
   logic [1:0]                 quad_ff [N];
   logic signed [CORDIC_W-1:0] x_ff    [N];
   logic signed [CORDIC_W-1:0] y_ff    [N];
   logic signed [Z_W-1:0]      z_ff    [N];

   logic signed [Z_W-1:0] z_init;

   // Quadrant remainder scaled to 2^-32 turn
   assign z_init = Z_W'({angle[A-3:0], {(32 - A){1'b0}}});

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic                       v_prev;
      logic [SIDE_W-1:0]          s_prev;
      logic [1:0]                 q_prev;
      logic signed [CORDIC_W-1:0] x_prev, y_prev, dx, dy, x_in, y_in;
      logic signed [Z_W-1:0]      z_prev, z_in;

      if (k == 0) begin : g_first
         assign v_prev = in_valid;
         assign s_prev = in_side;
         assign q_prev = angle[A-1:A-2];
         assign x_prev = CORDIC_X0;
         assign y_prev = '0;
         assign z_prev = z_init;
      end else begin : g_next
         assign v_prev = vld_ff[k-1];
         assign s_prev = side_ff[k-1];
         assign q_prev = quad_ff[k-1];
         assign x_prev = x_ff[k-1];
         assign y_prev = y_ff[k-1];
         assign z_prev = z_ff[k-1];
      end

      // Micro-rotation toward z = 0
      always_comb begin
         dx = y_prev >>> k;
         dy = x_prev >>> k;
         if (!z_prev[Z_W-1]) begin
            x_in = x_prev - dx;
            y_in = y_prev + dy;
            z_in = z_prev - atan_turn32(k);
         end else begin
            x_in = x_prev + dx;
            y_in = y_prev - dy;
            z_in = z_prev + atan_turn32(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= s_prev;
            quad_ff[k] <= q_prev;
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            z_ff[k]    <= z_in;
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_side  = side_ff[N-1];
   assign quad      = quad_ff[N-1];
   assign cos_q     = x_ff[N-1];
   assign sin_q     = y_ff[N-1];

endmodule

### hw/rtl/eopg_scale.sv
// Quadrant map, radius scaling and placement against the overlay bounds.
// Two register stages; final fields leave combinationally. Depends on eopg_pkg.
`timescale 1ns / 1ps

module eopg_scale #(
   parameter int COORD_BITS = eopg_pkg::COORD_BITS_DEF,
   parameter int SIDE_W     = 4 * COORD_BITS + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_valid,
   input  logic [SIDE_W-1:0]                   in_side,
   input  logic [1:0]                          quad,
   input  logic signed [eopg_pkg::CORDIC_W-1:0] cos_q,
   input  logic signed [eopg_pkg::CORDIC_W-1:0] sin_q,
   input  logic [eopg_pkg::REG_W-1:0]          overlay_width,
   input  logic [eopg_pkg::REG_W-1:0]          overlay_height,
   output logic                                out_valid,
   output logic [COORD_BITS-1:0]               pixel_x,
   output logic [COORD_BITS-1:0]               pixel_y,
   output logic                                pixel_valid,
   output logic                                preview_style,
   output logic                                last_sample
);
   import eopg_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int PW  = C - 1 + CORDIC_W;
   localparam int OW  = C + 5;
   localparam int CMW = OW + REG_W;

   logic signed [CORDIC_W-1:0] cs, sn;
   logic [CORDIC_W-1:0]        magx_in, magy_in;

   logic                v1_ff, v2_ff;
   logic [SIDE_W-1:0]   s1_ff, s2_ff;
   logic [CORDIC_W-1:0] magx_ff, magy_ff;
   logic                sgx1_ff, sgy1_ff, sgx2_ff, sgy2_ff;
   logic [PW-1:0]       prx_ff, pry_ff;

   logic [C-1:0] cx, cy;
   logic [C-2:0] rx1, ry1, rx2, ry2;
   logic         preview, live, last;
   logic [C+2:0] px_off, py_off;
   logic signed [OW-1:0] offx, offy, px, py;
   logic         in_x, in_y, draw;

   // Quadrant map and magnitude split
   always_comb begin
      case (quad)
         2'd0: begin
            cs = cos_q;
            sn = sin_q;
         end
         2'd1: begin
            cs = -sin_q;
            sn = cos_q;
         end
         2'd2: begin
            cs = -cos_q;
            sn = -sin_q;
         end
         default: begin
            cs = sin_q;
            sn = -cos_q;
         end
      endcase
      magx_in = cs[CORDIC_W-1] ? CORDIC_W'(-cs) : CORDIC_W'(cs);
      magy_in = sn[CORDIC_W-1] ? CORDIC_W'(-sn) : CORDIC_W'(sn);
   end

   assign rx1 = s1_ff[3*C-2:2*C];
   assign ry1 = s1_ff[4*C-3:3*C-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // Stage 1: magnitudes; stage 2: radius products
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= in_side;
         magx_ff <= magx_in;
         magy_ff <= magy_in;
         sgx1_ff <= cs[CORDIC_W-1];
         sgy1_ff <= sn[CORDIC_W-1];
         s2_ff   <= s1_ff;
         sgx2_ff <= sgx1_ff;
         sgy2_ff <= sgy1_ff;
         prx_ff  <= PW'(rx1) * PW'(magx_ff);
         pry_ff  <= PW'(ry1) * PW'(magy_ff);
      end
   end

   // Unpack the side word
   always_comb begin
      cx      = s2_ff[C-1:0];
      cy      = s2_ff[2*C-1:C];
      rx2     = s2_ff[3*C-2:2*C];
      ry2     = s2_ff[4*C-3:3*C-1];
      preview = s2_ff[4*C-2];
      live    = s2_ff[4*C-1];
      last    = s2_ff[4*C];
   end

   // Truncate toward zero, place at the center, check the bounds
   always_comb begin
      px_off = prx_ff[PW-1:FRAC_BITS];
      py_off = pry_ff[PW-1:FRAC_BITS];
      offx   = sgx2_ff ? -$signed({2'b00, px_off}) : $signed({2'b00, px_off});
      offy   = sgy2_ff ? -$signed({2'b00, py_off}) : $signed({2'b00, py_off});
      px     = $signed({5'b00000, cx}) + offx;
      py     = $signed({5'b00000, cy}) + offy;
      in_x   = !px[OW-1] && (CMW'($unsigned(px)) < CMW'(overlay_width));
      in_y   = !py[OW-1] && (CMW'($unsigned(py)) < CMW'(overlay_height));
      draw   = live && in_x && in_y && (rx2 != '0) && (ry2 != '0);
   end

   assign out_valid     = v2_ff;
   assign pixel_x       = draw ? px[C-1:0] : '0;
   assign pixel_y       = draw ? py[C-1:0] : '0;
   assign pixel_valid   = draw;
   assign preview_style = preview;
   assign last_sample   = last;

endmodule

### hw/rtl/ellipse_outline_point_generator.sv
// Ellipse outline point generator: one outline pixel per input word, fully
// pipelined. A word is accepted every cycle while the pipeline moves. Its result
// passes through one entry stage, one stage per angle bit in the restoring
// divider, 30 CORDIC stages, two scaling stages and the output register.
// Throughput is one word per cycle; the whole pipeline holds when the result side
// stalls. Overlay width and height are written through the csr port; the user
// must do so only while the pipeline is empty, which the block does not enforce.
// Depends on eopg_pkg, eopg_setup, eopg_divider, eopg_cordic and eopg_scale.
`timescale 1ns / 1ps

module ellipse_outline_point_generator #(
   parameter int COORD_BITS = eopg_pkg::COORD_BITS_DEF,
   parameter int ANGLE_BITS = eopg_pkg::ANGLE_BITS_DEF,
   parameter int REQ_W      = ((4 * COORD_BITS + eopg_pkg::IDX_W + 7) / 8) * 8,
   parameter int RSP_W      = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request: tdata = start_x, start_y, end_x, end_y, sample_index (low first)
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,
   // tuser = overlay_mode
   input  logic [eopg_pkg::MODE_W-1:0]   req_tuser,
   // Response: tdata = pixel_x, pixel_y, pixel_valid (low first)
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,
   // tuser = preview_style; tlast = last_sample
   output logic                          rsp_tuser,
   output logic                          rsp_tlast,
   // Register write port
   input  logic                          csr_we,
   input  logic                          csr_addr,
   input  logic [eopg_pkg::REG_W-1:0]    csr_wdata
);
   import eopg_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int SIDE_W = 4 * C + 1;

   logic adv;

   logic [REG_W-1:0] width_ff, height_ff;

   logic              s_vld;
   logic [SIDE_W-1:0] s_side;
   logic [C:0]        s_segs, s_rem;

   logic              d_vld;
   logic [SIDE_W-1:0] d_side;
   logic [ANGLE_BITS-1:0] d_angle;

   logic              c_vld;
   logic [SIDE_W-1:0] c_side;
   logic [1:0]        c_quad;
   logic signed [CORDIC_W-1:0] c_cos, c_sin;

   logic         k_vld, k_pv, k_prev, k_last;
   logic [C-1:0] k_px, k_py;

   logic             rsp_vld_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic             rsp_user_ff, rsp_last_ff;

   // Whole pipeline moves when the output register is free or being taken
   assign adv        = !rsp_vld_ff || rsp_tready;
   assign req_tready = adv;

   // Overlay bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= OVERLAY_RESET;
         height_ff <= OVERLAY_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   eopg_setup #(
      .COORD_BITS (C),
      .SIDE_W     (SIDE_W)
   ) u_setup (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_tvalid),
      .start_x      (req_tdata[C-1:0]),
      .start_y      (req_tdata[2*C-1:C]),
      .end_x        (req_tdata[3*C-1:2*C]),
      .end_y        (req_tdata[4*C-1:3*C]),
      .overlay_mode (req_tuser),
      .sample_index (req_tdata[4*C+IDX_W-1:4*C]),
      .out_valid    (s_vld),
      .side         (s_side),
      .segs         (s_segs),
      .rem_init     (s_rem)
   );

   eopg_divider #(
      .COORD_BITS (C),
      .ANGLE_BITS (ANGLE_BITS),
      .SIDE_W     (SIDE_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_vld),
      .in_side   (s_side),
      .segs      (s_segs),
      .rem_init  (s_rem),
      .out_valid (d_vld),
      .out_side  (d_side),
      .angle     (d_angle)
   );

   eopg_cordic #(
      .ANGLE_BITS (ANGLE_BITS),
      .SIDE_W     (SIDE_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (d_vld),
      .in_side   (d_side),
      .angle     (d_angle),
      .out_valid (c_vld),
      .out_side  (c_side),
      .quad      (c_quad),
      .cos_q     (c_cos),
      .sin_q     (c_sin)
   );

   eopg_scale #(
      .COORD_BITS (C),
      .SIDE_W     (SIDE_W)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (c_vld),
      .in_side        (c_side),
      .quad           (c_quad),
      .cos_q          (c_cos),
      .sin_q          (c_sin),
      .overlay_width  (width_ff),
      .overlay_height (height_ff),
      .out_valid      (k_vld),
      .pixel_x        (k_px),
      .pixel_y        (k_py),
      .pixel_valid    (k_pv),
      .preview_style  (k_prev),
      .last_sample    (k_last)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= k_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= RSP_W'({k_pv, k_py, k_px});
         rsp_user_ff <= k_prev;
         rsp_last_ff <= k_last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### tb/ellipse_outline_point_generator_tb.sv
// Testbench for ellipse_outline_point_generator: directed table, then random words,
// checked against typed-in results or a CORDIC predictor of the outline point.
// Depends on eopg_pkg and the generator RTL.
`timescale 1ns / 1ps

module ellipse_outline_point_generator_tb;
   import eopg_pkg::*;

   localparam int CBITS      = 12;
   localparam int ABITS      = 16;
   localparam int STAGES     = 30;
   localparam int DRAIN_WAIT = 80;
   localparam int LIMIT      = 300000;
   localparam int HOLD_LEN   = 400;

   typedef struct packed {
      logic [CBITS-1:0] px;
      logic [CBITS-1:0] py;
      logic             on;
      logic             style;
      logic             last;
   } pixel_t;

   typedef struct packed {
      logic [CBITS-1:0] sx;
      logic [CBITS-1:0] sy;
      logic [CBITS-1:0] ex;
      logic [CBITS-1:0] ey;
      logic [1:0]       mode;
      logic [IDX_W-1:0] idx;
   } drag_t;

   // directed row: word, whether the result is typed in, and that result
   typedef struct packed {
      drag_t  d;
      logic   typed;
      pixel_t res;
   } dir_row_t;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [63:0]      req_tdata = '0;
   logic [1:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;
   logic             rsp_tuser;
   logic             rsp_tlast;
   logic             csr_we = 1'b0;
   logic             csr_addr = 1'b0;
   logic [REG_W-1:0] csr_wdata = '0;

   ellipse_outline_point_generator dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   longint         atan_tab [STAGES] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
      5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

   longint         ovl_width  = 4096;
   longint         ovl_height = 4096;
   pixel_t         pending_pixels[$];
   bit             failed = 0;
   int unsigned    cycles = 0;
   int             burst_left = 0;
   bit             hold_req = 0;
   bit             hold_done = 0;
   int             hold_left = 0;
   int             stall_style = 0;

   // outline point as the block computes it
   function automatic pixel_t outline_point(drag_t d);
      longint cx, cy, rx, ry, segs, x, y, z, dx, dy, cs, sn, px, py, mag;
      longint unsigned ang;
      logic [1:0] quad;
      pixel_t p;
      p = '0;
      if (d.mode == MODE_NONE || d.mode == 2'd3) return p;
      p.style = (d.mode == MODE_LIVE);
      cx = (longint'(d.sx) + longint'(d.ex)) >> 1;
      cy = (longint'(d.sy) + longint'(d.ey)) >> 1;
      rx = (d.ex > d.sx) ? longint'(d.ex) - d.sx : longint'(d.sx) - d.ex;
      ry = (d.ey > d.sy) ? longint'(d.ey) - d.sy : longint'(d.sy) - d.ey;
      rx = rx >> 1;
      ry = ry >> 1;
      if (rx == 0 || ry == 0) return p;
      segs = 4 * ((rx > ry) ? rx : ry);
      if (longint'(d.idx) >= segs) return p;
      p.last = (longint'(d.idx) == segs - 1);
      ang = (longint'(d.idx) << ABITS) / segs;
      quad = ang[ABITS-1 -: 2];
      z = longint'(ang & ((64'd1 << (ABITS - 2)) - 1)) << (32 - ABITS);
      x = 652032874;
      y = 0;
      for (int k = 0; k < STAGES; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[k];
         end else begin
            x += dx; y -= dy; z += atan_tab[k];
         end
      end
      case (quad)
         2'd0: begin cs = x;  sn = y;  end
         2'd1: begin cs = -y; sn = x;  end
         2'd2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
      // offsets truncate toward zero
      mag = (cs < 0) ? -cs : cs;
      mag = (rx * mag) >> 30;
      px = cx + ((cs < 0) ? -mag : mag);
      mag = (sn < 0) ? -sn : sn;
      mag = (ry * mag) >> 30;
      py = cy + ((sn < 0) ? -mag : mag);
      if (px >= 0 && py >= 0 && px < ovl_width && py < ovl_height) begin
         p.px = px[CBITS-1:0];
         p.py = py[CBITS-1:0];
         p.on = 1'b1;
      end
      return p;
   endfunction

   // random drag: mostly well-formed outlines, some past the end, some noise
   function automatic drag_t random_drag();
      drag_t d;
      int kind, dlt, big;
      longint rx, ry, segs;
      d.sx = $urandom; d.sy = $urandom; d.ex = $urandom; d.ey = $urandom;
      d.mode = $urandom;
      d.idx = $urandom;
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
         d.mode = ($urandom_range(0, 1) != 0) ? MODE_LIVE : MODE_COMMIT;
         if ($urandom_range(0, 2) == 0) begin
            // small radii keep the sweep short
            big = $urandom_range(0, 24);
            dlt = $urandom_range(0, big);
            d.ex = (d.sx > 2048) ? d.sx - dlt : d.sx + dlt;
            dlt = $urandom_range(0, big);
            d.ey = (d.sy > 2048) ? d.sy - dlt : d.sy + dlt;
         end
         rx = ((d.ex > d.sx) ? longint'(d.ex) - d.sx : longint'(d.sx) - d.ex) >> 1;
         ry = ((d.ey > d.sy) ? longint'(d.ey) - d.sy : longint'(d.sy) - d.ey) >> 1;
         segs = 4 * ((rx > ry) ? rx : ry);
         if (segs > 0) begin
            if (kind < 72) d.idx = $urandom_range(0, segs - 1);
            else if (kind < 78) d.idx = segs - 1;
            else if (segs < 8192) d.idx = segs;
         end
      end
      return d;
   endfunction

   // offer one word, in bursts with random gaps, and log its expected pixel
   task automatic send_word(drag_t d, logic typed, pixel_t res);
      if (burst_left == 0) begin
         if (req_tvalid) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 20 : 4)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, d.idx, d.ey, d.ex, d.sy, d.sx};
      req_tuser  <= d.mode;
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(typed ? res : outline_point(d));
      burst_left--;
   endtask

   // stop offering and let every expected pixel come back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_overlay(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
      drain();
      csr_we    <= 1'b1;
      csr_addr  <= CSR_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= CSR_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we    <= 1'b0;
      ovl_width  = w;
      ovl_height = h;
   endtask

   // result side: stall pattern, one long hold-off, and the checker
   always @(posedge clock) begin
      pixel_t want, got;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (cycles % 97 == 0) stall_style = $urandom_range(0, 2);
      if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_style)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{px: rsp_tdata[11:0], py: rsp_tdata[23:12], on: rsp_tdata[24],
                 style: rsp_tuser, last: rsp_tlast};
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word, got %p", $time, got);
            failed = 1;
         end else begin
            want = pending_pixels.pop_front();
            if (got.px !== want.px) begin
               $display("%0t: pixel_x expected %0d got %0d", $time, want.px, got.px);
               failed = 1;
            end
            if (got.py !== want.py) begin
               $display("%0t: pixel_y expected %0d got %0d", $time, want.py, got.py);
               failed = 1;
            end
            if (got.on !== want.on) begin
               $display("%0t: pixel_valid expected %0d got %0d", $time, want.on, got.on);
               failed = 1;
            end
            if (got.style !== want.style) begin
               $display("%0t: preview_style expected %0d got %0d", $time, want.style,
                        got.style);
               failed = 1;
            end
            if (got.last !== want.last) begin
               $display("%0t: last_sample expected %0d got %0d", $time, want.last,
                        got.last);
               failed = 1;
            end
         end
      end
   end

   dir_row_t dir_tab [0:15];
   logic [REG_W-1:0] phase_w [0:6] = '{13'd4096, 13'd8191, 13'd0, 13'd4096, 13'd1,
                                       13'd2048, 13'd0};
   logic [REG_W-1:0] phase_h [0:6] = '{13'd4096, 13'd8191, 13'd4096, 13'd0, 13'd1,
                                       13'd1500, 13'd0};

   initial begin
      // typed rows: no overlay, zero radius, index past outline; the rest predicted
      dir_tab = '{
         '{'{12'd10, 12'd10, 12'd100, 12'd100, MODE_NONE, 13'd3}, 1'b1, '0},
         '{'{12'd10, 12'd10, 12'd100, 12'd100, 2'd3, 13'd3}, 1'b1, '0},
         '{'{12'd5, 12'd5, 12'd5, 12'd90, MODE_LIVE, 13'd0}, 1'b1,
           '{12'd0, 12'd0, 1'b0, 1'b1, 1'b0}},
         '{'{12'd5, 12'd5, 12'd90, 12'd6, MODE_COMMIT, 13'd0}, 1'b1, '0},
         '{'{12'd0, 12'd0, 12'd8, 12'd8, MODE_LIVE, 13'd16}, 1'b1,
           '{12'd0, 12'd0, 1'b0, 1'b1, 1'b0}},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, MODE_COMMIT, 13'd8191}, 1'b1, '0},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, MODE_COMMIT, 13'd0}, 1'b0, '0},
         '{'{12'd4095, 12'd4095, 12'd0, 12'd0, MODE_LIVE, 13'd2047}, 1'b0, '0},
         '{'{12'd0, 12'd4095, 12'd4095, 12'd0, MODE_LIVE, 13'd4094}, 1'b0, '0},
         '{'{12'd4095, 12'd0, 12'd0, 12'd4095, MODE_COMMIT, 13'd6141}, 1'b0, '0},
         '{'{12'd0, 12'd0, 12'd4095, 12'd4095, MODE_LIVE, 13'd8187}, 1'b0, '0},
         '{'{12'd0, 12'd0, 12'd2, 12'd2, MODE_COMMIT, 13'd0}, 1'b0, '0},
         '{'{12'd0, 12'd0, 12'd2, 12'd2, MODE_COMMIT, 13'd1}, 1'b0, '0},
         '{'{12'd2, 12'd2, 12'd0, 12'd0, MODE_LIVE, 13'd2}, 1'b0, '0},
         '{'{12'd2, 12'd2, 12'd0, 12'd0, MODE_LIVE, 13'd3}, 1'b0, '0},
         '{'{12'd100, 12'd3000, 12'd3000, 12'd100, MODE_COMMIT, 13'd1000}, 1'b0, '0}};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_word(dir_tab[i].d, dir_tab[i].typed, dir_tab[i].res);

      // random phases, each under its own overlay size
      for (int ph = 0; ph < 7; ph++) begin
         if (ph < 6) write_overlay(phase_w[ph], phase_h[ph]);
         else write_overlay($urandom_range(0, 8191), $urandom_range(0, 8191));
         for (int n = 0; n < 115; n++) begin
            if (ph == 1 && n == 10) hold_req = 1;
            send_word(random_drag(), 1'b0, '0);
         end
      end

      drain();
      if (!failed) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
